// ===== rtl/frg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frg_pkg: shared types and constants for the fraction reducer
// Field width, request and result structs, and the job record that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t numerator_in;
    value_t denominator_in;
  } in_item_t;

  typedef struct packed {
    value_t numerator_out;
    value_t denominator_out;
    value_t common_divisor;
  } out_item_t;

  // bypass: one operand is zero, the fraction passes with a divisor of 1
  typedef struct packed {
    value_t numerator;
    value_t denominator;
    logic   bypass;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/frg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frg_front: request intake and classification
// Registers one request, flags the zero-operand case, and offers the job
// to the queue. A new request is taken as soon as the held one moves on.
// ----------------------------------------------------------------------------
module frg_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire frg_pkg::in_item_t in_data,
  output logic            push_valid,
  input  wire             push_ready,
  output frg_pkg::job_t   push_job
);

  logic          held;
  frg_pkg::job_t job;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_job   = job;

  // holding register, control
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  // holding register, payload with zero classification
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job.numerator   <= in_data.numerator_in;
      job.denominator <= in_data.denominator_in;
      job.bypass      <= (in_data.numerator_in == '0) || (in_data.denominator_in == '0);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frg_queue: short job queue between front and back end
// Circular buffer of jobs with a fill count; the head is read directly.
// ----------------------------------------------------------------------------
module frg_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           push_valid,
  output logic          push_ready,
  input  wire frg_pkg::job_t push_job,
  output logic          pop_valid,
  input  wire           pop_ready,
  output frg_pkg::job_t pop_job
);

  localparam int PTR_W = (frg_pkg::QUEUE_DEPTH > 1) ? $clog2(frg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(frg_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(frg_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(frg_pkg::QUEUE_DEPTH);

  frg_pkg::job_t    entries [frg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("job queue over-filled");

endmodule
`default_nettype wire

// ===== rtl/frg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frg_back: divisor search and exact division
// Binary GCD, one subtract or shift per cycle, then a restoring divider
// pair that retires one quotient bit of each operand per cycle. The result
// sits in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module frg_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               pop_valid,
  output logic              pop_ready,
  input  wire frg_pkg::job_t pop_job,
  output logic              out_valid,
  input  wire               out_ready,
  output frg_pkg::out_item_t out_data
);

  localparam int W  = frg_pkg::VALUE_WIDTH;
  localparam int KW = frg_pkg::SHIFT_WIDTH;
  localparam logic [KW-1:0] LAST_BIT = KW'(W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GCD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state;
  frg_pkg::value_t      ga;
  frg_pkg::value_t      gb;
  logic [KW-1:0]        shift_k;
  frg_pkg::value_t      divisor;
  frg_pkg::value_t      num_q;
  frg_pkg::value_t      den_q;
  frg_pkg::value_t      num_rem;
  frg_pkg::value_t      den_rem;
  logic [KW-1:0]        bit_cnt;
  logic [W:0]           num_trial;
  logic [W:0]           den_trial;
  logic                 num_fit;
  logic                 den_fit;
  logic                 out_free;

  assign pop_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // one restoring step for each operand
  assign num_trial = {num_rem, num_q[W-1]};
  assign den_trial = {den_rem, den_q[W-1]};
  assign num_fit   = (num_trial >= {1'b0, divisor});
  assign den_fit   = (den_trial >= {1'b0, divisor});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= pop_job.bypass ? ST_DONE : ST_GCD;
          end
        end
        ST_GCD: begin
          if (ga == '0 || gb == '0) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bit_cnt == LAST_BIT) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num_q   <= pop_job.numerator;
        den_q   <= pop_job.denominator;
        ga      <= pop_job.numerator;
        gb      <= pop_job.denominator;
        shift_k <= '0;
        divisor <= frg_pkg::value_t'(1);
        num_rem <= '0;
        den_rem <= '0;
        bit_cnt <= '0;
      end
      ST_GCD: begin
        if (ga == '0) begin
          divisor <= frg_pkg::value_t'(gb << shift_k);
        end else if (gb == '0) begin
          divisor <= frg_pkg::value_t'(ga << shift_k);
        end else if (!ga[0] && !gb[0]) begin
          ga      <= ga >> 1;
          gb      <= gb >> 1;
          shift_k <= shift_k + KW'(1);
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
      ST_DIV: begin
        num_rem <= num_fit ? W'(num_trial - {1'b0, divisor}) : num_trial[W-1:0];
        den_rem <= den_fit ? W'(den_trial - {1'b0, divisor}) : den_trial[W-1:0];
        num_q   <= {num_q[W-2:0], num_fit};
        den_q   <= {den_q[W-2:0], den_fit};
        bit_cnt <= bit_cnt + KW'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.numerator_out   <= num_q;
      out_data.denominator_out <= den_q;
      out_data.common_divisor  <= divisor;
    end
  end

  a_gcd_operands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCD) |-> (ga != '0 || gb != '0))
    else $error("GCD search lost both operands");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_DONE) |-> (divisor != '0))
    else $error("zero divisor in divide phase");

  a_exact_division: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (num_rem == '0 && den_rem == '0))
    else $error("divisor does not divide both operands");

endmodule
`default_nettype wire

// ===== rtl/fraction_reduce_by_gcd_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_reduce_by_gcd_top: reduce a fraction to lowest terms
// Requests are handled one at a time by the shared GCD and divider sequence in
//   the back end, which takes no new job until it has finished the last; zero
//   operands skip the GCD search and the division. The front and queue buffer
//   up to three further requests meanwhile.
// Reset clears the front register, queue and sequencer; no result is pending.
// ----------------------------------------------------------------------------
module fraction_reduce_by_gcd_top (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire frg_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output frg_pkg::out_item_t out_data
);

  logic          push_valid;
  logic          push_ready;
  frg_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  frg_pkg::job_t pop_job;

  // intake and classification
  frg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // decoupling queue
  frg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // divisor search, division and result register
  frg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
